/* hdl/assert_macros.svh */
// Assertion macros for the box filter block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`endif
`endif

/* hdl/bfb_pkg.sv */
// Shared constants and types of the box filter block.
`timescale 1ns / 1ps
package bfb_pkg;
  localparam int MAX_KERNEL = 7;
  localparam int MAX_PITCH = 4096;
  localparam int COLOR_CH = 3;
  localparam int LINE_ROWS = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
  localparam int WIN_DEPTH = MAX_KERNEL * COLOR_CH;
  localparam int ROW_CAP = 8192;
  localparam int KLIM = (MAX_KERNEL % 2 == 0) ? MAX_KERNEL - 1 : MAX_KERNEL;
  localparam int KERN_W = 3;
  localparam int KTAB = 1 << KERN_W;
  localparam int DIM_W = 13;
  localparam int ADDR_W = $clog2(MAX_PITCH);
  localparam int CNT_W = $clog2(MAX_PITCH + 1);
  localparam int ROW_W = $clog2(ROW_CAP + 1);
  localparam int SLOT_W = (LINE_ROWS > 1) ? $clog2(LINE_ROWS) : 1;
  localparam int COL_W = $clog2(MAX_KERNEL * 255 + 1);
  localparam int SUM_W = $clog2(MAX_KERNEL * MAX_KERNEL * 255 + 1);
  localparam int NUM_W = $clog2(MAX_KERNEL * MAX_KERNEL * 511 + 1);
  localparam int RECIP_SHIFT = NUM_W + $clog2(2 * MAX_KERNEL * MAX_KERNEL) + 1;
  localparam int RECIP_W = RECIP_SHIFT;
  localparam int QW = 9;
  localparam int DIV_W = 2 * KERN_W + 1;

  typedef enum logic [2:0] {
    REG_KERNEL = 3'd0,
    REG_WIDTH  = 3'd1,
    REG_HEIGHT = 3'd2,
    REG_COLOR  = 3'd3,
    REG_PITCH  = 3'd4
  } cfg_reg_t;
endpackage

/* hdl/bfb_ram.sv */
// Generic single-write, registered-read RAM.
`timescale 1ns / 1ps
module bfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* hdl/bfb_cell.sv */
// One cell of the window column shift chain.
`timescale 1ns / 1ps
module bfb_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    shift,
  input  logic [bfb_pkg::COL_W-1:0] din,
  output logic [bfb_pkg::COL_W-1:0] dout
);
  import bfb_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else if (shift) begin
      dout <= din;
    end
  end
endmodule

/* hdl/box_filter_blur_unit.sv */
// An accepted byte passes the stage 1, 2, 3 and 4 registers before its result reaches the output register.
// Throughput: one byte per cycle; the line store RAM read and window chain run
// one column per cycle, and a stalled output holds the whole pipeline.
// Reset: registers return to defaults (k 3, 640 x 480, gray, pitch 640); the
// line store is not cleared and is valid only where written in the frame.
`timescale 1ns / 1ps
module box_filter_blur_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [2:0]                 cfg_index,
  input  logic [bfb_pkg::DIM_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 sample,
  input  logic                       frame_start,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 blurred,
  output logic                       frame_last
);
  import bfb_pkg::*;

  `include "assert_macros.svh"

  localparam int WCAP3 = MAX_PITCH / COLOR_CH;

  logic [KERN_W-1:0] kernel_size;
  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic              color_mode;
  logic [DIM_W-1:0]  line_pitch;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_size  <= KERN_W'(3);
      image_width  <= DIM_W'(640);
      image_height <= DIM_W'(480);
      color_mode   <= 1'b0;
      line_pitch   <= DIM_W'(640);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KERNEL: kernel_size  <= cfg_data[KERN_W-1:0];
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        REG_COLOR:  color_mode   <= cfg_data[0];
        REG_PITCH:  line_pitch   <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [KERN_W-1:0] k0, k1, k_eff;
  logic [DIM_W-1:0]  w_eff;
  logic [CNT_W-1:0]  act, p0, p1, pitch;
  logic [KERN_W+1:0] km1, kch;

  always_comb begin
    k0 = (kernel_size == '0) ? KERN_W'(1) : kernel_size;
    k1 = k0[0] ? k0 : k0 - KERN_W'(1);
    k_eff = (k1 > KERN_W'(KLIM)) ? KERN_W'(KLIM) : k1;
    if (color_mode && image_width > DIM_W'(WCAP3)) begin
      w_eff = DIM_W'(WCAP3);
    end else if (image_width > DIM_W'(MAX_PITCH)) begin
      w_eff = DIM_W'(MAX_PITCH);
    end else begin
      w_eff = image_width;
    end
    act = color_mode ? CNT_W'((DIM_W+2)'(w_eff) * 3) : CNT_W'(w_eff);
    p0 = ((DIM_W+1)'(line_pitch) > (DIM_W+1)'(MAX_PITCH)) ? CNT_W'(MAX_PITCH)
                                                          : CNT_W'(line_pitch);
    p1 = (p0 < act) ? act : p0;
    pitch = (p1 == '0) ? CNT_W'(1) : p1;
    km1 = (KERN_W+2)'(k_eff) - (KERN_W+2)'(1);
    kch = color_mode ? km1 + (km1 << 1) : km1;
  end

  // position counters
  logic [ROW_W-1:0]  row_count, cur_r;
  logic [CNT_W-1:0]  byte_count, cur_c;
  logic [SLOT_W-1:0] row_slot, cur_slot;
  logic wrap, live, take_rows, emit, last, accept, advance;

  assign in_stall = out_valid && out_stall;
  assign advance  = !in_stall;
  assign accept   = in_valid && advance;

  always_comb begin
    wrap = !frame_start && (byte_count >= pitch);
    if (frame_start) begin
      cur_r = '0;
      cur_slot = '0;
    end else if (wrap && (row_count < ROW_W'(ROW_CAP))) begin
      cur_r = row_count + ROW_W'(1);
      cur_slot = (row_slot == SLOT_W'(LINE_ROWS - 1)) ? '0 : row_slot + SLOT_W'(1);
    end else begin
      cur_r = row_count;
      cur_slot = row_slot;
    end
    cur_c = (frame_start || wrap) ? '0 : byte_count;
    live = (cur_r < ROW_W'(image_height)) && (cur_c < act);
    take_rows = ((ROW_W+1)'(cur_r) + (ROW_W+1)'(1)) >= (ROW_W+1)'(k_eff);
    emit = live && take_rows && (DIM_W'(k_eff) <= w_eff) &&
           (DIM_W'(k_eff) <= image_height) && (cur_c >= CNT_W'(kch));
    last = (cur_r == ROW_W'(image_height) - ROW_W'(1)) && (cur_c == act - CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count  <= '0;
      byte_count <= '0;
      row_slot   <= '0;
    end else if (accept) begin
      row_count  <= cur_r;
      byte_count <= cur_c + CNT_W'(1);
      row_slot   <= cur_slot;
    end
  end

  // line store, one RAM per stored line
  logic [7:0] rd [LINE_ROWS];

  for (genvar j = 0; j < LINE_ROWS; j++) begin : g_line
    bfb_ram #(.WIDTH(8), .DEPTH(MAX_PITCH)) u_ram (
      .clk  (clk),
      .we   (accept && live && (cur_slot == SLOT_W'(j))),
      .waddr(cur_c[ADDR_W-1:0]),
      .wdata(sample),
      .re   (advance),
      .raddr(cur_c[ADDR_W-1:0]),
      .rdata(rd[j])
    );
  end

  // stage 1: column sum
  logic              s1_valid, s1_live, s1_emit, s1_last, s1_take;
  logic [SLOT_W-1:0] s1_slot;
  logic [7:0]        s1_sample;
  logic [COL_W-1:0]  col;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_live   <= live;
      s1_emit   <= emit;
      s1_last   <= last;
      s1_take   <= take_rows;
      s1_slot   <= cur_slot;
      s1_sample <= sample;
    end
  end

  // the current row's own slot still reads the line LINE_ROWS rows back
  always_comb begin
    logic [SLOT_W:0] d;
    col = COL_W'(s1_sample);
    for (int j = 0; j < LINE_ROWS; j++) begin
      if (s1_slot >= SLOT_W'(j)) begin
        d = (SLOT_W+1)'(s1_slot) - (SLOT_W+1)'(j);
      end else begin
        d = (SLOT_W+1)'(s1_slot) + (SLOT_W+1)'(LINE_ROWS - j);
      end
      if (s1_take && ((d != '0) ? (d < (SLOT_W+1)'(k_eff))
                                : (LINE_ROWS < int'(k_eff)))) begin
        col = col + COL_W'(rd[j]);
      end
    end
  end

  // window column chain
  logic [COL_W-1:0] win [WIN_DEPTH];
  logic             shift;

  assign shift = advance && s1_valid && s1_live;

  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_win
    bfb_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .shift(shift),
      .din  ((i == 0) ? col : win[(i == 0) ? 0 : i - 1]),
      .dout (win[i])
    );
  end

  // stage 2: window sum over same-channel taps
  logic             s2_valid, s2_last;
  logic [SUM_W-1:0] wsum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid && s1_live && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_last <= s1_last;
    end
  end

  always_comb begin
    wsum = '0;
    for (int i = 0; i < MAX_KERNEL; i++) begin
      if (i < int'(k_eff)) begin
        wsum = wsum + SUM_W'(color_mode ? win[i * COLOR_CH] : win[i]);
      end
    end
  end

  // stage 3: reciprocal multiply
  logic [2*KERN_W-1:0]      kk;
  logic [DIV_W-1:0]         dv;
  logic                     s3_valid, s3_last;
  logic [NUM_W-1:0]         s3_num;
  logic [RECIP_W-1:0]       recip_tab [KTAB];
  logic [NUM_W+RECIP_W-1:0] prod;

  assign kk = (2*KERN_W)'(k_eff) * (2*KERN_W)'(k_eff);
  assign dv = {kk, 1'b0};

  for (genvar g = 0; g < KTAB; g++) begin : g_recip
    localparam longint Dv = (g == 0) ? 2 : 2 * g * g;
    localparam longint Rv = ((longint'(1) << RECIP_SHIFT) + Dv - 1) / Dv;
    assign recip_tab[g] = RECIP_W'(Rv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_last <= s2_last;
      s3_num  <= NUM_W'({wsum, 1'b0}) + NUM_W'(kk);
    end
  end

  assign prod = (NUM_W+RECIP_W)'(s3_num) * (NUM_W+RECIP_W)'(recip_tab[k_eff]);

  // stage 4: quotient estimate may be one high
  logic                s4_valid, s4_last;
  logic [QW-1:0]       s4_q;
  logic [NUM_W-1:0]    s4_num;
  logic [QW+DIV_W-1:0] chk;
  logic [QW-1:0]       q_fix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (advance) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_last <= s3_last;
      s4_q    <= prod[RECIP_SHIFT +: QW];
      s4_num  <= s3_num;
    end
  end

  assign chk   = (QW+DIV_W)'(s4_q) * (QW+DIV_W)'(dv);
  assign q_fix = (chk > (QW+DIV_W)'(s4_num)) ? s4_q - QW'(1) : s4_q;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      blurred    <= q_fix[7:0];
      frame_last <= s4_last;
    end
  end

  `ASSERT_ALWAYS(a_slot_range, row_slot < SLOT_W'(LINE_ROWS), "line slot out of range")
  `ASSERT_IMPLY(a_stall_cause, in_stall, out_valid, "input stalled with no pending result")
  `ASSERT_IMPLY(a_quot_close, s4_valid, (QW+DIV_W+1)'(chk) <= (QW+DIV_W+1)'(s4_num) + (QW+DIV_W+1)'(dv), "reciprocal estimate off by more than one")
endmodule
